### design/crfe_pkg.sv
// crfe_pkg: shared types and constants of the clipped rectangle fill engine
// item layouts, request and job codes, default sizes; no dependencies

package crfe_pkg;

    localparam int DEF_SCREEN_WIDTH  = 64;
    localparam int DEF_SCREEN_HEIGHT = 64;
    localparam int DEF_QUEUE_DEPTH   = 4;

    // job fields sized for the largest supported screen (1024 x 1024)
    localparam int ADDR_W  = 20;
    localparam int EXT_W   = 11;
    localparam int COORD_W = 14;
    localparam int PIX_W   = 32;

    localparam logic [PIX_W-1:0] RGB_MASK = 32'h00FF_FFFF;

    localparam logic [2:0] REQ_CLEAR  = 3'd0;
    localparam logic [2:0] REQ_FILL   = 3'd1;
    localparam logic [2:0] REQ_FRAME  = 3'd2;
    localparam logic [2:0] REQ_INVERT = 3'd3;
    localparam logic [2:0] REQ_READ   = 3'd4;

    typedef logic signed [COORD_W-1:0] t_coord;

    typedef enum logic [1:0] {
        OP_NOP    = 2'd0,
        OP_WRITE  = 2'd1,
        OP_INVERT = 2'd2,
        OP_READ   = 2'd3
    } t_op;

    typedef struct packed {
        logic [2:0]        req_type;
        logic signed [11:0] x_pos;
        logic signed [11:0] y_pos;
        logic signed [11:0] width;
        logic signed [11:0] height;
        logic [PIX_W-1:0]  color;
    } t_req;

    typedef struct packed {
        logic [PIX_W-1:0] read_pixel;
        logic             off_screen;
    } t_rsp;

    // one clipped box for the back end
    typedef struct packed {
        t_op               op;
        logic [ADDR_W-1:0] base;
        logic [EXT_W-1:0]  w;
        logic [EXT_W-1:0]  h;
        logic [PIX_W-1:0]  color;
        logic              last;
        logic              off;
    } t_job;

endpackage

### design/crfe_ram.sv
// crfe_ram: generic single write port, single read port ram
// registered read data; no dependencies

module crfe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### design/crfe_front.sv
// crfe_front: accepts command items, clips each box and hands jobs on
// depends on crfe_pkg

module crfe_front #(
    parameter int SCREEN_WIDTH  = crfe_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = crfe_pkg::DEF_SCREEN_HEIGHT
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            push,
    output logic            full,
    input  crfe_pkg::t_req  i_req,
    input  logic            i_hold,
    output logic            o_q_push,
    input  logic            i_q_full,
    output crfe_pkg::t_job  o_job
);
    import crfe_pkg::*;

    localparam int XW    = $clog2(SCREEN_WIDTH);
    localparam int YW    = $clog2(SCREEN_HEIGHT);
    localparam int AW    = $clog2(SCREEN_WIDTH * SCREEN_HEIGHT);
    localparam int MSB   = COORD_W - 1;
    localparam logic [AW-1:0] W_A = AW'(SCREEN_WIDTH);
    localparam t_coord SW     = t_coord'(SCREEN_WIDTH);
    localparam t_coord SH     = t_coord'(SCREEN_HEIGHT);
    localparam t_coord C_ONE  = t_coord'(1);
    localparam t_coord C_ZERO = t_coord'(0);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_CLIP = 3'b010,
        F_PUSH = 3'b100
    } t_fstate;

    t_fstate    r_state, n_state;
    t_req       r_req, n_req;
    logic [1:0] r_step, n_step;
    logic       r_any, n_any;
    t_coord     r_cx, r_cy, r_cw, r_ch;
    logic       r_hit, r_last;

    t_coord bx, by, bw, bh, cx, cy, cw, ch, ovx, ovy;
    logic   known, bad_frame, hit, last;
    logic [AW-1:0] base;

    assign full = (r_state != F_IDLE) || i_hold;

    // box of the current step
    always_comb begin
        bx = t_coord'(r_req.x_pos);
        by = t_coord'(r_req.y_pos);
        bw = t_coord'(r_req.width);
        bh = t_coord'(r_req.height);
        unique case (r_req.req_type)
            REQ_CLEAR: begin
                bx = C_ZERO;
                by = C_ZERO;
                bw = SW;
                bh = SH;
            end
            REQ_READ: begin
                bw = C_ONE;
                bh = C_ONE;
            end
            REQ_FRAME: begin
                unique case (r_step)
                    2'd0: bh = C_ONE;
                    2'd1: begin
                        by = by + bh - C_ONE;
                        bh = C_ONE;
                    end
                    2'd2: bw = C_ONE;
                    default: begin
                        bx = bx + bw - C_ONE;
                        bw = C_ONE;
                    end
                endcase
            end
            default: ;
        endcase
    end

    // clip to the screen
    always_comb begin
        cx = bx;
        cw = bw;
        if (bx[MSB]) begin
            cw = bw + bx;
            cx = C_ZERO;
        end
        cy = by;
        ch = bh;
        if (by[MSB]) begin
            ch = bh + by;
            cy = C_ZERO;
        end
        ovx = SW - (cx + cw);
        ovy = SH - (cy + ch);
        if (ovx[MSB]) begin
            cw = SW - cx;
        end
        if (ovy[MSB]) begin
            ch = SH - cy;
        end
        known     = (r_req.req_type <= REQ_READ);
        bad_frame = (r_req.req_type == REQ_FRAME) &&
                    ((r_req.width <= 12'sd0) || (r_req.height <= 12'sd0));
        hit  = known && !bad_frame && !cw[MSB] && (cw != C_ZERO) &&
               !ch[MSB] && (ch != C_ZERO);
        last = (r_req.req_type != REQ_FRAME) || bad_frame || (r_step == 2'd3);
    end

    assign base = (AW'(r_cy[YW-1:0]) * W_A) + AW'(r_cx[XW-1:0]);

    always_comb begin
        o_job       = '0;
        o_job.base  = ADDR_W'(base);
        o_job.w     = r_cw[EXT_W-1:0];
        o_job.h     = r_ch[EXT_W-1:0];
        o_job.color = r_req.color;
        o_job.last  = r_last;
        o_job.off   = (r_req.req_type <= REQ_READ) && !(r_any || r_hit);
        o_job.op    = OP_NOP;
        if (r_hit) begin
            unique case (r_req.req_type)
                REQ_INVERT: o_job.op = OP_INVERT;
                REQ_READ:   o_job.op = OP_READ;
                default:    o_job.op = OP_WRITE;
            endcase
        end
    end

    assign o_q_push = (r_state == F_PUSH) && !i_q_full;

    always_comb begin
        n_state = r_state;
        n_req   = r_req;
        n_step  = r_step;
        n_any   = r_any;
        unique case (r_state)
            F_IDLE: begin
                if (push && !full) begin
                    n_req   = i_req;
                    n_step  = 2'd0;
                    n_any   = 1'b0;
                    n_state = F_CLIP;
                end
            end
            F_CLIP: n_state = F_PUSH;
            F_PUSH: begin
                if (!i_q_full) begin
                    n_any = r_any || r_hit;
                    if (r_last) begin
                        n_state = F_IDLE;
                    end else begin
                        n_step  = r_step + 2'd1;
                        n_state = F_CLIP;
                    end
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_step  <= 2'd0;
            r_any   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_any   <= n_any;
        end
        r_req <= n_req;
        if (r_state == F_CLIP) begin
            r_cx   <= cx;
            r_cy   <= cy;
            r_cw   <= cw;
            r_ch   <= ch;
            r_hit  <= hit;
            r_last <= last;
        end
    end

`ifndef NO_ASSERTIONS
    a_step_frame_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != F_IDLE && r_step != 2'd0) |-> r_req.req_type == REQ_FRAME)
        else $error("box step advanced on a single box command");
    a_hold_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == F_IDLE && i_hold) |=> r_state == F_IDLE)
        else $error("item taken while the store was being cleared");
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_q_push && r_last) |=> r_state == F_IDLE)
        else $error("front kept working after the final box");
`endif

endmodule

### design/crfe_queue.sv
// crfe_queue: short job queue between the front and back ends
// depends on crfe_pkg

module crfe_queue #(
    parameter int DEPTH = crfe_pkg::DEF_QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  crfe_pkg::t_job i_data,
    output logic           o_full,
    input  logic           i_pop,
    output crfe_pkg::t_job o_data,
    output logic           o_empty
);
    import crfe_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] P_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] C_FULL = CW'(DEPTH);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wptr, n_wptr, r_rptr, n_rptr;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == C_FULL);
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (do_push) begin
            n_wptr = (r_wptr == P_LAST) ? '0 : r_wptr + 1'b1;
        end
        if (do_pop) begin
            n_rptr = (r_rptr == P_LAST) ? '0 : r_rptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

### design/crfe_back.sv
// crfe_back: walks each clipped box over the frame store, clears it after
// reset and holds the result item; depends on crfe_pkg and crfe_ram

module crfe_back #(
    parameter int SCREEN_WIDTH  = crfe_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = crfe_pkg::DEF_SCREEN_HEIGHT
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  crfe_pkg::t_job i_job,
    input  logic           i_q_empty,
    output logic           o_q_pop,
    output logic           o_clearing,
    output crfe_pkg::t_rsp o_rsp,
    output logic           empty,
    input  logic           pop
);
    import crfe_pkg::*;

    localparam int DEPTH = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [AW-1:0] W_A    = AW'(SCREEN_WIDTH);
    localparam logic [AW-1:0] A_LAST = AW'(DEPTH - 1);

    typedef enum logic [5:0] {
        ST_CLR   = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_RUN   = 6'b000100,
        ST_DRAIN = 6'b001000,
        ST_RDW   = 6'b010000,
        ST_DONE  = 6'b100000
    } t_bstate;

    t_bstate          r_state, n_state;
    t_job             r_job, n_job;
    logic [AW-1:0]    r_addr, n_addr, r_row, n_row, r_wb_addr;
    logic [EXT_W-1:0] r_col, n_col, r_rowc, n_rowc;
    logic             r_wb_v, n_wb_v;
    logic [PIX_W-1:0] r_pix, n_pix;
    t_rsp             r_out, n_out;
    logic             r_out_v, n_out_v;

    logic             we;
    logic [AW-1:0]    waddr, raddr;
    logic [PIX_W-1:0] wdata, rdata;
    logic             last_col, last_row, out_free;

    crfe_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign o_clearing = (r_state == ST_CLR);
    assign o_q_pop    = (r_state == ST_IDLE) && !i_q_empty;
    assign raddr      = (r_state == ST_IDLE) ? i_job.base[AW-1:0] : r_addr;
    assign last_col   = (r_col == r_job.w - 1'b1);
    assign last_row   = (r_rowc == r_job.h - 1'b1);
    assign out_free   = !r_out_v || pop;
    assign o_rsp      = r_out;
    assign empty      = !r_out_v;
    assign n_wb_v     = (r_state == ST_RUN) && (r_job.op == OP_INVERT);

    // store write port
    always_comb begin
        we    = 1'b0;
        waddr = r_addr;
        wdata = '0;
        priority if (r_state == ST_CLR) begin
            we = 1'b1;
        end else if (r_wb_v) begin
            we    = 1'b1;
            waddr = r_wb_addr;
            wdata = rdata ^ RGB_MASK;
        end else if (r_state == ST_RUN && r_job.op == OP_WRITE) begin
            we    = 1'b1;
            wdata = r_job.color;
        end
    end

    always_comb begin
        n_state = r_state;
        n_job   = r_job;
        n_addr  = r_addr;
        n_row   = r_row;
        n_col   = r_col;
        n_rowc  = r_rowc;
        n_pix   = r_pix;
        n_out   = r_out;
        n_out_v = r_out_v && !pop;
        unique case (r_state)
            ST_CLR: begin
                n_addr = r_addr + 1'b1;
                if (r_addr == A_LAST) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (!i_q_empty) begin
                    n_job  = i_job;
                    n_pix  = '0;
                    n_addr = i_job.base[AW-1:0];
                    n_row  = i_job.base[AW-1:0];
                    n_col  = '0;
                    n_rowc = '0;
                    unique case (i_job.op)
                        OP_WRITE, OP_INVERT: n_state = ST_RUN;
                        OP_READ:             n_state = ST_RDW;
                        default:             n_state = i_job.last ? ST_DONE : ST_IDLE;
                    endcase
                end
            end
            ST_RUN: begin
                if (!last_col) begin
                    n_col  = r_col + 1'b1;
                    n_addr = r_addr + 1'b1;
                end else if (!last_row) begin
                    n_col  = '0;
                    n_rowc = r_rowc + 1'b1;
                    n_row  = r_row + W_A;
                    n_addr = r_row + W_A;
                end else if (r_job.op == OP_INVERT) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_state = r_job.last ? ST_DONE : ST_IDLE;
                end
            end
            ST_DRAIN: n_state = r_job.last ? ST_DONE : ST_IDLE;
            ST_RDW: begin
                n_pix   = rdata;
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    n_out.read_pixel = r_pix;
                    n_out.off_screen = r_job.off;
                    n_out_v          = 1'b1;
                    n_state          = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLR;
            r_addr  <= '0;
            r_col   <= '0;
            r_rowc  <= '0;
            r_wb_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            r_col   <= n_col;
            r_rowc  <= n_rowc;
            r_wb_v  <= n_wb_v;
            r_out_v <= n_out_v;
        end
        r_job     <= n_job;
        r_row     <= n_row;
        r_pix     <= n_pix;
        r_out     <= n_out;
        r_wb_addr <= r_addr;
    end

`ifndef NO_ASSERTIONS
    a_run_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_RUN |-> (r_job.op == OP_WRITE || r_job.op == OP_INVERT))
        else $error("box walk started for a job with no pixels");
    a_wb_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wb_v |-> (r_state == ST_RUN || r_state == ST_DRAIN))
        else $error("invert write-back outside its box");
    a_read_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_RDW |-> !r_wb_v)
        else $error("pixel read overlaps a pending store write");
`endif

endmodule

### design/clipped_rect_fill_engine.sv
// clipped_rect_fill_engine: top level of the clipped rectangle fill engine
// depends on crfe_pkg, crfe_front, crfe_queue, crfe_back, crfe_ram
//
// command items enter through push/full: an item is taken at a clock edge with
// push high and full low. each item yields exactly one result item, offered in
// order on o_rsp while empty is low and taken at an edge with pop high.
// the front takes an item, clips its box (four boxes for a frame of positive
// size), a clip state then a push state per box, and queues the boxes; the
// back walks each box over the frame store at one pixel per cycle through the
// single store write port; a clear covers all SCREEN_WIDTH * SCREEN_HEIGHT
// pixels (4096 by default).
// full is high while the front still works on an item; up to QUEUE_DEPTH boxes
// wait between front and back.
// after reset the store is swept to zero with full held high. a result that
// is not popped stalls the back,
// then the box queue, then the front; nothing is lost.

module clipped_rect_fill_engine #(
    parameter int SCREEN_WIDTH  = crfe_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = crfe_pkg::DEF_SCREEN_HEIGHT,
    parameter int QUEUE_DEPTH   = crfe_pkg::DEF_QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           push,
    output logic           full,
    input  crfe_pkg::t_req i_req,
    output logic           empty,
    input  logic           pop,
    output crfe_pkg::t_rsp o_rsp
);
    import crfe_pkg::*;

    t_job q_in, q_out;
    logic q_push, q_full, q_pop, q_empty, clearing;

    crfe_front #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_req    (i_req),
        .i_hold   (clearing),
        .o_q_push (q_push),
        .i_q_full (q_full),
        .o_job    (q_in)
    );

    crfe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_empty (q_empty)
    );

    crfe_back #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job      (q_out),
        .i_q_empty  (q_empty),
        .o_q_pop    (q_pop),
        .o_clearing (clearing),
        .o_rsp      (o_rsp),
        .empty      (empty),
        .pop        (pop)
    );

endmodule

### bench/crfe_checker.sv
// crfe_checker: watches the command and result queues of clipped_rect_fill_engine
// keeps a shadow frame store, predicts every result item and compares it
// depends on crfe_pkg

module crfe_checker #(
    parameter int SCREEN_W = crfe_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_H = crfe_pkg::DEF_SCREEN_HEIGHT
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  logic           i_full,
    input  crfe_pkg::t_req i_req,
    input  logic           i_empty,
    input  logic           i_pop,
    input  crfe_pkg::t_rsp i_rsp,
    output int             o_fail_count,
    output int             o_pending
);
    import crfe_pkg::*;

    logic [PIX_W-1:0] shadow_store [SCREEN_W*SCREEN_H];
    t_rsp             results_due [$];
    t_rsp             want;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        $display("%0t mismatch %s: got %h want %h", $realtime, what, got, exp_val);
        o_fail_count++;
    endtask

    function automatic bit clip_rect(inout int x, inout int y, inout int w, inout int h);
        if (x < 0) begin
            w += x;
            x = 0;
        end
        if (y < 0) begin
            h += y;
            y = 0;
        end
        if (x + w > SCREEN_W) begin
            w = SCREEN_W - x;
        end
        if (y + h > SCREEN_H) begin
            h = SCREEN_H - y;
        end
        return (w > 0) && (h > 0);
    endfunction

    // flip set: xor the rgb bits, else write colour
    function automatic bit paint_rect(int x, int y, int w, int h,
                                      logic [PIX_W-1:0] colour, bit flip);
        int r;
        int c;
        int idx;
        if (!clip_rect(x, y, w, h)) begin
            return 1'b0;
        end
        for (r = 0; r < h; r++) begin
            for (c = 0; c < w; c++) begin
                idx = (y + r) * SCREEN_W + (x + c);
                if (flip) begin
                    shadow_store[idx] ^= RGB_MASK;
                end else begin
                    shadow_store[idx] = colour;
                end
            end
        end
        return 1'b1;
    endfunction

    function automatic t_rsp predict_cmd(t_req cmd);
        t_rsp res;
        int   x;
        int   y;
        int   w;
        int   h;
        bit   drawn;
        res = '0;
        x = $signed(cmd.x_pos);
        y = $signed(cmd.y_pos);
        w = $signed(cmd.width);
        h = $signed(cmd.height);
        case (cmd.req_type)
            REQ_CLEAR: begin
                foreach (shadow_store[i]) shadow_store[i] = cmd.color;
            end
            REQ_FILL: begin
                res.off_screen = !paint_rect(x, y, w, h, cmd.color, 1'b0);
            end
            REQ_FRAME: begin
                if (w <= 0 || h <= 0) begin
                    res.off_screen = 1'b1;
                end else begin
                    drawn = paint_rect(x, y, w, 1, cmd.color, 1'b0);
                    drawn = paint_rect(x, y + h - 1, w, 1, cmd.color, 1'b0) | drawn;
                    drawn = paint_rect(x, y, 1, h, cmd.color, 1'b0) | drawn;
                    drawn = paint_rect(x + w - 1, y, 1, h, cmd.color, 1'b0) | drawn;
                    res.off_screen = !drawn;
                end
            end
            REQ_INVERT: begin
                res.off_screen = !paint_rect(x, y, w, h, '0, 1'b1);
            end
            REQ_READ: begin
                if (x >= 0 && x < SCREEN_W && y >= 0 && y < SCREEN_H) begin
                    res.read_pixel = shadow_store[y * SCREEN_W + x];
                end else begin
                    res.off_screen = 1'b1;
                end
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (shadow_store[i]) shadow_store[i] = '0;
            results_due.delete();
        end else begin
            if (i_push && !i_full) begin
                results_due.push_back(predict_cmd(i_req));
            end
            if (i_pop && !i_empty) begin
                if (results_due.size() == 0) begin
                    report_mismatch("result item with none due", i_rsp.read_pixel, '0);
                end else begin
                    want = results_due.pop_front();
                    if (i_rsp.read_pixel !== want.read_pixel) begin
                        report_mismatch("read_pixel", i_rsp.read_pixel, want.read_pixel);
                    end
                    if (i_rsp.off_screen !== want.off_screen) begin
                        report_mismatch("off_screen", 32'(i_rsp.off_screen),
                                        32'(want.off_screen));
                    end
                end
            end
        end
        o_pending = results_due.size();
    end

endmodule

### bench/tb_top.sv
// tb_top: stimulus and verdict for clipped_rect_fill_engine
// drives drawing commands and result pops with random idling; checking is in crfe_checker
// depends on crfe_pkg, crfe_checker and the engine rtl

module tb_top;
    import crfe_pkg::*;

    localparam int HOLD_CYCLES  = 400;
    localparam int RANDOM_ITEMS = 35;
    localparam int MAX_REQ      = 7;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic push;
    logic full;
    t_req i_req;
    logic empty;
    logic pop;
    t_rsp o_rsp;

    int fail_count;
    int pending;
    int send_idle_pct;
    int take_idle_pct;
    bit hold_req = 1'b0;

    clipped_rect_fill_engine dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_req   (i_req),
        .empty   (empty),
        .pop     (pop),
        .o_rsp   (o_rsp)
    );

    crfe_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_full       (full),
        .i_req        (i_req),
        .i_empty      (empty),
        .i_pop        (pop),
        .i_rsp        (o_rsp),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #(64'd30_000_000);
        $display("status: fail");
        $finish;
    end

    function automatic t_req rect_cmd(logic [2:0] kind, int x, int y, int w, int h,
                                      logic [PIX_W-1:0] colour);
        t_req cmd;
        cmd.req_type = kind;
        cmd.x_pos    = 12'(x);
        cmd.y_pos    = 12'(y);
        cmd.width    = 12'(w);
        cmd.height   = 12'(h);
        cmd.color    = colour;
        return cmd;
    endfunction

    function automatic int rand_coord();
        if ($urandom_range(9) == 0) begin
            return int'($signed(12'($urandom)));
        end
        return int'($urandom_range(80)) - 8;
    endfunction

    function automatic int rand_extent();
        if ($urandom_range(9) == 0) begin
            return int'($signed(12'($urandom)));
        end
        return int'($urandom_range(28)) - 4;
    endfunction

    function automatic t_req random_cmd();
        int         pick;
        logic [2:0] kind;
        pick = $urandom_range(99);
        if (pick < 3) begin
            kind = REQ_CLEAR;
        end else if (pick < 23) begin
            kind = REQ_FILL;
        end else if (pick < 38) begin
            kind = REQ_FRAME;
        end else if (pick < 53) begin
            kind = REQ_INVERT;
        end else if (pick < 94) begin
            kind = REQ_READ;
        end else begin
            kind = 3'($urandom_range(MAX_REQ, int'(REQ_READ) + 1));
        end
        return rect_cmd(kind, rand_coord(), rand_coord(), rand_extent(), rand_extent(),
                        $urandom);
    endfunction

    task automatic send_cmd(input t_req cmd);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push  <= 1'b1;
        i_req <= cmd;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        push <= 1'b0;
        wait (pending == 0);
    endtask

    task automatic send_random(input int count);
        repeat (count) send_cmd(random_cmd());
    endtask

    // result side: random idling, or one long hold-off when asked
    initial begin
        pop = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end else begin
                pop <= ($urandom_range(99) >= take_idle_pct);
            end
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        push          = 1'b0;
        i_req         = '0;
        send_idle_pct = 10;
        take_idle_pct = 80;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_cmd(rect_cmd(REQ_READ, 0, 0, 0, 0, '0));
        send_cmd(rect_cmd(REQ_READ, 63, 63, 0, 0, '1));
        send_cmd(rect_cmd(REQ_READ, -1, 0, 0, 0, '0));
        send_cmd(rect_cmd(REQ_READ, 2047, -2048, 2047, -2048, '1));
        send_cmd(rect_cmd(REQ_READ, 0, 64, 0, 0, '0));
        send_cmd(rect_cmd(REQ_CLEAR, 0, 0, 0, 0, 32'hFFFF_FFFF));
        send_cmd(rect_cmd(REQ_READ, 17, 40, 0, 0, '0));
        send_cmd(rect_cmd(REQ_FILL, -2048, -2048, 2047, 2047, '0));
        send_cmd(rect_cmd(REQ_FILL, 2047, 2047, 2047, 2047, '0));
        send_cmd(rect_cmd(REQ_FILL, 5, 5, 0, 7, 32'h1111_1111));
        send_cmd(rect_cmd(REQ_FILL, 5, 5, -2048, 3, 32'h2222_2222));
        send_cmd(rect_cmd(REQ_FILL, -10, -10, 2047, 2047, 32'h8000_0001));
        send_cmd(rect_cmd(REQ_FILL, 3, 4, 5, 6, 32'hA5A5_A5A5));
        send_cmd(rect_cmd(REQ_INVERT, -2, 60, 6, 10, '0));
        send_cmd(rect_cmd(REQ_INVERT, 64, 0, 4, 4, '0));
        send_cmd(rect_cmd(REQ_FRAME, 10, 10, 0, 5, 32'h0101_0101));
        send_cmd(rect_cmd(REQ_FRAME, 10, 10, 5, -1, 32'h0202_0202));
        send_cmd(rect_cmd(REQ_FRAME, 10, 10, 20, 15, 32'h00FF_00FF));
        send_cmd(rect_cmd(REQ_FRAME, -5, -5, 20, 20, 32'h7E7E_7E7E));
        send_cmd(rect_cmd(REQ_FRAME, -1, -1, 66, 66, 32'h3C3C_3C3C));
        send_cmd(rect_cmd(REQ_FRAME, 63, 63, 1, 1, 32'hC3C3_C3C3));
        send_cmd(rect_cmd(REQ_READ + 3'd1, 3, 3, 3, 3, 32'hDEAD_BEEF));
        send_cmd(rect_cmd(3'(MAX_REQ), -2048, 2047, -2048, 2047, '1));
        send_cmd(rect_cmd(REQ_READ, 63, 60, 0, 0, '0));
        send_cmd(rect_cmd(REQ_READ, 14, 24, 0, 0, '0));
        send_random(RANDOM_ITEMS);
        drain_results();

        // long hold-off on the result side while commands keep coming
        send_idle_pct = 0;
        hold_req      = 1'b1;
        repeat (12) begin
            if ($urandom_range(3) == 0) begin
                send_cmd(rect_cmd(REQ_FILL, $urandom_range(60), $urandom_range(60), 2, 2,
                                  $urandom));
            end else begin
                send_cmd(rect_cmd(REQ_READ, $urandom_range(63), $urandom_range(63), 0, 0,
                                  '0));
            end
        end

        send_idle_pct = 80;
        take_idle_pct = 10;
        send_random(RANDOM_ITEMS);
        drain_results();

        send_idle_pct = 0;
        take_idle_pct = 0;
        send_random(RANDOM_ITEMS);
        drain_results();
        repeat (20) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
